// ===== rtl/kmer_count_table_with_degree_defines.svh =====
// Assertion macros for the k-mer count table back end.
// Depends on nothing; included by modules that assert.
`ifndef KMER_COUNT_TABLE_WITH_DEGREE_DEFINES_SVH
`define KMER_COUNT_TABLE_WITH_DEGREE_DEFINES_SVH
`define KCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define KCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/kct_pkg.sv =====
// Types and constants for the k-mer count table.
// Depends on nothing.
package kct_pkg;
  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_DEGREE = 2'd2;
  localparam logic [1:0] REQ_ERASE = 2'd3;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_ZERO = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_SAT = 3'd4;
  localparam int KEY_W = 62;
  localparam int AMT_W = 32;

  typedef struct packed {
    logic [1:0] req_type;
    logic [KEY_W-1:0] kmer;
    logic [AMT_W-1:0] amount;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_CLEAR, BK_SCAN, BK_PROBE, BK_DONE
  } bk_state_t;
endpackage

// ===== rtl/kct_front.sv =====
// Front end: takes in items, masks the key and holds them in a two-entry queue.
// Depends on kct_pkg.
module kct_front #(
  parameter int KMER_LEN = 31
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic [1:0] req_type,
  input  logic [kct_pkg::KEY_W-1:0] kmer,
  input  logic [kct_pkg::AMT_W-1:0] amount,
  input  logic pop,
  output logic full,
  output logic avail,
  output kct_pkg::item_t head
);
  localparam int KB = 2 * KMER_LEN;
  kct_pkg::item_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  kct_pkg::item_t it;
  always_comb begin
    it.req_type = req_type;
    it.amount = amount;
    it.kmer = '0;
    it.kmer[KB-1:0] = kmer[KB-1:0];
  end
  assign full = cnt_r == 2'd2;
  assign avail = cnt_r != 2'd0;
  assign head = q_r[rp_r];
  always_comb cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
    if (push) q_r[wp_r] <= it;
  end
endmodule

// ===== rtl/kct_back.sv =====
// Back end: scans the table memory for keys and executes each request.
// Depends on kct_pkg and the assertion macro header.
`include "kmer_count_table_with_degree_defines.svh"
module kct_back #(
  parameter int KMER_LEN = 31,
  parameter int TABLE_DEPTH = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic avail,
  input  kct_pkg::item_t head,
  output logic pop,
  output logic out_valid,
  output logic out_found,
  output logic [31:0] out_count_value,
  output logic [3:0] out_pred_mask,
  output logic [3:0] out_succ_mask,
  output logic [2:0] out_pred_count,
  output logic [2:0] out_succ_count,
  output logic [10:0] out_entries,
  output logic [2:0] out_status
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KB = 2 * KMER_LEN;
  localparam int CW = COUNT_BITS;
  localparam int EW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] CMAX = '1;

  logic [KB-1:0] key_mem [TABLE_DEPTH];
  logic [CW-1:0] cnt_mem [TABLE_DEPTH];
  logic vld_mem [TABLE_DEPTH];
  kct_pkg::bk_state_t st_r, st_nxt;
  logic [AW:0] idx_r, idx_nxt;
  logic [3:0] pr_r, pr_nxt;
  kct_pkg::item_t it_r;
  logic [KB-1:0] rk_r;
  logic [CW-1:0] rc_r;
  logic rv_r;
  logic rd_d_r;
  logic [AW-1:0] ra_r;
  logic hit_r, hit_nxt, fr_r, fr_nxt;
  logic [AW-1:0] hs_r, hs_nxt, fs_r, fs_nxt;
  logic [CW-1:0] hc_r, hc_nxt;
  logic [7:0] nb_r, nb_nxt;
  logic [EW-1:0] tot_r;
  logic [KB-1:0] probe_key;
  logic rd_en, scan_end;
  logic [KB-1:0] key;
  logic [CW-1:0] amt_c;
  logic amt_big;
  logic wr_en, set_v, clr_v;
  logic [AW-1:0] wr_a;
  logic [KB-1:0] wr_k;
  logic [CW-1:0] wr_c, sum_c;
  logic vwr_en, vwr_d;
  logic [AW-1:0] vwr_a;
  logic sum_ovf;
  logic [CW:0] sum_w;
  logic [2:0] st_code;

  assign key = it_r.kmer[KB-1:0];
  assign amt_c = CW'(it_r.amount);
  assign amt_big = (it_r.amount >> CW) != '0;

  always_comb begin
    probe_key = key;
    if (pr_r >= 4'd1 && pr_r <= 4'd4)
      probe_key = {2'(pr_r - 4'd1), key[KB-1:2]};
    else if (pr_r >= 4'd5 && pr_r <= 4'd8)
      probe_key = {key[KB-3:0], 2'(pr_r - 4'd5)};
  end

  assign rd_en = (st_r == kct_pkg::BK_SCAN) && (idx_r < (AW+1)'(TABLE_DEPTH));
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rk_r <= key_mem[idx_r[AW-1:0]];
      rc_r <= cnt_mem[idx_r[AW-1:0]];
      rv_r <= vld_mem[idx_r[AW-1:0]];
      ra_r <= idx_r[AW-1:0];
    end else rv_r <= 1'b0;
    if (wr_en) begin
      key_mem[wr_a] <= wr_k;
      cnt_mem[wr_a] <= wr_c;
    end
    if (vwr_en) vld_mem[vwr_a] <= vwr_d;
  end

  assign sum_w = {1'b0, hc_r} + {1'b0, amt_c};
  assign sum_ovf = sum_w[CW] | amt_big;
  assign sum_c = sum_ovf ? CMAX : sum_w[CW-1:0];
  assign scan_end = (st_r == kct_pkg::BK_SCAN) && !rd_en && !rd_d_r;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    pr_nxt = pr_r;
    hit_nxt = hit_r;
    hs_nxt = hs_r;
    hc_nxt = hc_r;
    fr_nxt = fr_r;
    fs_nxt = fs_r;
    nb_nxt = nb_r;
    pop = 1'b0;
    wr_en = 1'b0;
    wr_a = hs_r;
    wr_k = key;
    wr_c = '0;
    vwr_en = 1'b0;
    vwr_a = hs_r;
    vwr_d = 1'b0;
    set_v = 1'b0;
    clr_v = 1'b0;
    st_code = kct_pkg::ST_OK;
    out_valid = 1'b0;
    out_found = 1'b0;
    out_count_value = '0;
    out_pred_mask = '0;
    out_succ_mask = '0;
    out_pred_count = '0;
    out_succ_count = '0;
    if (rd_d_r && rv_r && rk_r == probe_key && (pr_r != 4'd0 || !hit_r)) begin
      if (pr_r == 4'd0) begin
        hit_nxt = 1'b1;
        hs_nxt = ra_r;
        hc_nxt = rc_r;
      end else nb_nxt[3'(pr_r - 4'd1)] = 1'b1;
    end
    if (rd_d_r && !rv_r && !fr_r && pr_r == 4'd0) begin
      fr_nxt = 1'b1;
      fs_nxt = ra_r;
    end
    case (st_r)
      kct_pkg::BK_CLEAR: begin
        vwr_en = 1'b1;
        vwr_a = idx_r[AW-1:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (AW+1)'(TABLE_DEPTH - 1)) begin
          idx_nxt = '0;
          st_nxt = kct_pkg::BK_IDLE;
        end
      end
      kct_pkg::BK_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          st_nxt = kct_pkg::BK_PROBE;
        end
      end
      kct_pkg::BK_PROBE: begin
        idx_nxt = '0;
        hit_nxt = 1'b0;
        fr_nxt = 1'b0;
        pr_nxt = 4'd0;
        nb_nxt = '0;
        st_nxt = kct_pkg::BK_SCAN;
      end
      kct_pkg::BK_SCAN: begin
        if (rd_en) idx_nxt = idx_r + 1'b1;
        if (scan_end) begin
          if (it_r.req_type == kct_pkg::REQ_DEGREE && hit_r && pr_r != 4'd8) begin
            pr_nxt = pr_r + 4'd1;
            idx_nxt = '0;
          end else st_nxt = kct_pkg::BK_DONE;
        end
      end
      kct_pkg::BK_DONE: begin
        out_valid = 1'b1;
        out_found = hit_r;
        out_count_value = hit_r ? 32'(64'(hc_r)) : '0;
        st_nxt = kct_pkg::BK_IDLE;
        case (it_r.req_type)
          kct_pkg::REQ_ADD: begin
            if (it_r.amount == '0) st_code = kct_pkg::ST_ZERO;
            else if (hit_r) begin
              wr_en = 1'b1;
              wr_k = key;
              wr_c = sum_c;
              out_count_value = 32'(64'(sum_c));
              if (sum_ovf) st_code = kct_pkg::ST_SAT;
            end else if (!fr_r) st_code = kct_pkg::ST_FULL;
            else begin
              wr_en = 1'b1;
              wr_a = fs_r;
              wr_c = amt_big ? CMAX : amt_c;
              vwr_en = 1'b1;
              vwr_a = fs_r;
              vwr_d = 1'b1;
              set_v = 1'b1;
              out_count_value = 32'(64'(wr_c));
              if (amt_big) st_code = kct_pkg::ST_SAT;
            end
          end
          kct_pkg::REQ_LOOKUP: if (!hit_r) st_code = kct_pkg::ST_MISSING;
          kct_pkg::REQ_DEGREE: begin
            if (!hit_r) st_code = kct_pkg::ST_MISSING;
            else begin
              out_pred_mask = nb_r[3:0];
              out_succ_mask = nb_r[7:4];
              out_pred_count = 3'($countones(nb_r[3:0]));
              out_succ_count = 3'($countones(nb_r[7:4]));
            end
          end
          kct_pkg::REQ_ERASE: begin
            if (!hit_r) st_code = kct_pkg::ST_MISSING;
            else begin
              vwr_en = 1'b1;
              clr_v = 1'b1;
              out_count_value = '0;
            end
          end
          default: st_code = kct_pkg::ST_OK;
        endcase
      end
      default: st_nxt = kct_pkg::BK_IDLE;
    endcase
  end
  assign out_status = st_code;
  assign out_entries = 11'(tot_r + EW'(set_v) - EW'(clr_v));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kct_pkg::BK_CLEAR;
      tot_r <= '0;
      idx_r <= '0;
      pr_r <= '0;
      hit_r <= 1'b0;
      fr_r <= 1'b0;
      nb_r <= '0;
      rd_d_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      pr_r <= pr_nxt;
      hit_r <= hit_nxt;
      fr_r <= fr_nxt;
      nb_r <= nb_nxt;
      rd_d_r <= rd_en;
      tot_r <= tot_r + EW'(set_v) - EW'(clr_v);
    end
    hs_r <= hs_nxt;
    hc_r <= hc_nxt;
    fs_r <= fs_nxt;
    if (pop) it_r <= head;
  end

  `KCT_ASSERT_IMPL(a_one_write, clk, rst_n, out_valid, !(set_v && clr_v), "set and clear together")
  `KCT_ASSERT_NEXT(a_done_idle, clk, rst_n, out_valid, st_r == kct_pkg::BK_IDLE, "no return to idle")
  `KCT_ASSERT_IMPL(a_tot_range, clk, rst_n, 1'b1, tot_r <= EW'(TABLE_DEPTH), "entry total overflow")
endmodule

// ===== rtl/kmer_count_table_with_degree.sv =====
// Top level: joins the front queue and the back end. Depends on kct_pkg, kct_front and kct_back.
// Flow: when idle, the back end pops an item from the front queue, passes a probe state, scans
// every table entry and raises the result strobe in the done state; a degree query of a present
// k-mer adds eight more scans, one per neighbour. A new item is taken only after the previous
// result; busy is high while the two-entry front queue is full. The result strobe lasts one cycle;
// the receiver cannot stall. Synchronous active-low reset, then a clearing pass empties the table.
module kmer_count_table_with_degree #(
  parameter int KMER_LEN = 31,
  parameter int TABLE_DEPTH = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_req_type,
  input  logic [61:0] in_kmer,
  input  logic [31:0] in_amount,
  output logic out_valid,
  output logic out_found,
  output logic [31:0] out_count_value,
  output logic [3:0] out_pred_mask,
  output logic [3:0] out_succ_mask,
  output logic [2:0] out_pred_count,
  output logic [2:0] out_succ_count,
  output logic [10:0] out_entries,
  output logic [2:0] out_status
);
  logic full, avail, pop;
  kct_pkg::item_t head;
  assign busy = full;
  kct_front #(.KMER_LEN(KMER_LEN)) u_front (
    .clk, .rst_n, .push(start & ~full), .req_type(in_req_type), .kmer(in_kmer),
    .amount(in_amount), .pop, .full, .avail, .head
  );
  kct_back #(.KMER_LEN(KMER_LEN), .TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS))
  u_back (
    .clk, .rst_n, .avail, .head, .pop, .out_valid, .out_found,
    .out_count_value, .out_pred_mask, .out_succ_mask, .out_pred_count,
    .out_succ_count, .out_entries, .out_status
  );
endmodule

// ===== dv/tb_kmer_count_table_with_degree.sv =====
// Testbench for the k-mer count table with de Bruijn degree queries.
// Items are driven from a queue. A predictor built on an associative array checks every result.
// Depends on kct_pkg and the kmer_count_table_with_degree RTL.
`timescale 1ns / 1ps

module tb_kmer_count_table_with_degree;

  localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;
  localparam int TABLE_SLOTS = 1024;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct packed {
    logic found;
    logic [31:0] count_value;
    logic [3:0] pred_mask;
    logic [3:0] succ_mask;
    logic [2:0] pred_cnt;
    logic [2:0] succ_cnt;
    logic [10:0] entries;
    logic [2:0] status;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [61:0] in_kmer = '0;
  logic [31:0] in_amount = '0;
  logic out_valid, out_found;
  logic [31:0] out_count_value;
  logic [3:0] out_pred_mask, out_succ_mask;
  logic [2:0] out_pred_count, out_succ_count, out_status;
  logic [10:0] out_entries;

  logic [31:0] kmer_counts [logic [61:0]];
  kct_pkg::item_t pending_items[$];
  reply_t expected_replies[$];
  logic [61:0] kmer_pool[$];
  logic [61:0] fill_keys[$];
  logic taken = 1'b0;
  int sent = 0;
  int total_items = 0;
  int errors = 0;
  longint cycles = 0;

  kmer_count_table_with_degree uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_kmer(in_kmer), .in_amount(in_amount),
    .out_valid(out_valid), .out_found(out_found), .out_count_value(out_count_value),
    .out_pred_mask(out_pred_mask), .out_succ_mask(out_succ_mask),
    .out_pred_count(out_pred_count), .out_succ_count(out_succ_count),
    .out_entries(out_entries), .out_status(out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, want, $time);
    errors++;
  endtask

  task automatic predict_request(input kct_pkg::item_t it, output reply_t r);
    logic [61:0] k;
    logic [61:0] nb;
    logic [1:0] b;
    logic present;
    logic [31:0] c;
    k = it.kmer;
    r = '0;
    present = kmer_counts.exists(k);
    c = present ? kmer_counts[k] : 32'd0;
    r.found = present;
    r.status = kct_pkg::ST_OK;
    case (it.req_type)
      kct_pkg::REQ_ADD: begin
        if (it.amount == 0) begin
          r.status = kct_pkg::ST_ZERO;
        end else if (present) begin
          if (COUNT_MAX - c < it.amount) begin
            c = COUNT_MAX;
            r.status = kct_pkg::ST_SAT;
          end else begin
            c = c + it.amount;
          end
          kmer_counts[k] = c;
        end else if (kmer_counts.num() >= TABLE_SLOTS) begin
          r.status = kct_pkg::ST_FULL;
        end else begin
          c = it.amount;
          kmer_counts[k] = c;
        end
      end
      kct_pkg::REQ_LOOKUP: begin
        if (!present) r.status = kct_pkg::ST_MISSING;
      end
      kct_pkg::REQ_DEGREE: begin
        if (!present) begin
          r.status = kct_pkg::ST_MISSING;
        end else begin
          for (int i = 0; i < 4; i++) begin
            b = i[1:0];
            nb = {b, k[61:2]};
            if (kmer_counts.exists(nb)) begin
              r.pred_mask[i] = 1'b1;
              r.pred_cnt++;
            end
            nb = {k[59:0], b};
            if (kmer_counts.exists(nb)) begin
              r.succ_mask[i] = 1'b1;
              r.succ_cnt++;
            end
          end
        end
      end
      default: begin
        if (!present) begin
          r.status = kct_pkg::ST_MISSING;
        end else begin
          kmer_counts.delete(k);
          c = 0;
        end
      end
    endcase
    r.count_value = c;
    r.entries = 11'(kmer_counts.num());
  endtask

  function automatic logic [61:0] random_kmer();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[61:0];
  endfunction

  task automatic queue_item(input logic [1:0] rt, input logic [61:0] k, input logic [31:0] amt);
    kct_pkg::item_t it;
    it.req_type = rt;
    it.kmer = k;
    it.amount = amt;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_random_item();
    int sel;
    logic [1:0] rt;
    logic [61:0] k;
    logic [31:0] amt;
    sel = $urandom_range(99);
    if (sel < 45) rt = kct_pkg::REQ_ADD;
    else if (sel < 68) rt = kct_pkg::REQ_LOOKUP;
    else if (sel < 80) rt = kct_pkg::REQ_DEGREE;
    else rt = kct_pkg::REQ_ERASE;
    if ($urandom_range(99) < 85) k = kmer_pool[$urandom_range(kmer_pool.size() - 1)];
    else k = random_kmer();
    sel = $urandom_range(99);
    if (sel < 8) amt = 0;
    else if (sel < 60) amt = $urandom_range(1, 100);
    else if (sel < 75) amt = COUNT_MAX - $urandom_range(0, 50);
    else amt = $urandom();
    queue_item(rt, k, amt);
  endtask

  initial begin
    logic [61:0] k;
    logic [61:0] chain;
    chain = random_kmer();
    for (int i = 0; i < 24; i++) begin
      kmer_pool.insert(kmer_pool.size(), chain);
      if ($urandom_range(3) == 0)
        kmer_pool.insert(kmer_pool.size(), {2'($urandom_range(3)), chain[61:2]});
      chain = {chain[59:0], 2'($urandom_range(3))};
    end

    k = kmer_pool[0];
    queue_item(kct_pkg::REQ_LOOKUP, k, 32'd0);
    queue_item(kct_pkg::REQ_DEGREE, k, 32'd1);
    queue_item(kct_pkg::REQ_ERASE, k, 32'd5);
    queue_item(kct_pkg::REQ_ADD, k, 32'd0);
    queue_item(kct_pkg::REQ_ADD, k, 32'd1);
    queue_item(kct_pkg::REQ_ADD, k, 32'd0);
    queue_item(kct_pkg::REQ_ADD, kmer_pool[1], COUNT_MAX);
    queue_item(kct_pkg::REQ_ADD, kmer_pool[1], 32'd1);
    queue_item(kct_pkg::REQ_ADD, kmer_pool[2], 32'h8000_0000);
    queue_item(kct_pkg::REQ_ADD, kmer_pool[2], 32'h8000_0000);
    queue_item(kct_pkg::REQ_ADD, 62'd0, 32'd7);
    queue_item(kct_pkg::REQ_ADD, {62{1'b1}}, 32'hffff_fffe);
    queue_item(kct_pkg::REQ_LOOKUP, {62{1'b1}}, 32'd0);
    queue_item(kct_pkg::REQ_DEGREE, kmer_pool[1], 32'd0);
    queue_item(kct_pkg::REQ_DEGREE, 62'd0, 32'd0);
    queue_item(kct_pkg::REQ_LOOKUP, kmer_pool[2], 32'd0);
    queue_item(kct_pkg::REQ_ERASE, kmer_pool[1], 32'd0);
    queue_item(kct_pkg::REQ_ERASE, 62'd0, 32'd0);
    queue_item(kct_pkg::REQ_DEGREE, kmer_pool[2], 32'd0);
    queue_item(kct_pkg::REQ_LOOKUP, kmer_pool[1], 32'd0);

    for (int i = 0; i < 60; i++) queue_random_item();

    for (int i = 0; i < TABLE_SLOTS + 4; i++) begin
      k = random_kmer();
      fill_keys.insert(fill_keys.size(), k);
      queue_item(kct_pkg::REQ_ADD, k, $urandom_range(1, 1000));
    end
    for (int i = 0; i < 6; i++)
      queue_item(kct_pkg::REQ_ADD, random_kmer(), $urandom_range(1, 9));
    for (int i = 0; i < 4; i++) queue_random_item();
    for (int i = 0; i < 20; i++) queue_item(kct_pkg::REQ_ERASE, fill_keys[i * 40], 32'd0);
    for (int i = 0; i < 20; i++) queue_random_item();
    total_items = pending_items.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    kct_pkg::item_t it;
    reply_t r;
    taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      it.req_type = in_req_type;
      it.kmer = in_kmer;
      it.amount = in_amount;
      predict_request(it, r);
      expected_replies.insert(expected_replies.size(), r);
    end
  end

  always @(negedge clk) begin
    int idle_pct;
    kct_pkg::item_t it;
    if (rst_n && (!start || taken)) begin
      idle_pct = (sent < total_items / 3) ? 25 : (sent < 2 * total_items / 3) ? 66 : 0;
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        it = pending_items.pop_front();
        in_req_type <= it.req_type;
        in_kmer <= it.kmer;
        in_amount <= it.amount;
        start <= 1'b1;
        sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    reply_t w;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        report("unexpected result", 64'(out_status), 64'd0);
      end else begin
        w = expected_replies.pop_front();
        if (out_found !== w.found) report("found", 64'(out_found), 64'(w.found));
        if (out_count_value !== w.count_value)
          report("count_value", 64'(out_count_value), 64'(w.count_value));
        if (out_pred_mask !== w.pred_mask)
          report("pred_mask", 64'(out_pred_mask), 64'(w.pred_mask));
        if (out_succ_mask !== w.succ_mask)
          report("succ_mask", 64'(out_succ_mask), 64'(w.succ_mask));
        if (out_pred_count !== w.pred_cnt)
          report("pred_count", 64'(out_pred_count), 64'(w.pred_cnt));
        if (out_succ_count !== w.succ_cnt)
          report("succ_count", 64'(out_succ_count), 64'(w.succ_cnt));
        if (out_entries !== w.entries) report("entries", 64'(out_entries), 64'(w.entries));
        if (out_status !== w.status) report("status", 64'(out_status), 64'(w.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    wait (total_items > 0 && rst_n);
    wait (pending_items.size() == 0 && !start && expected_replies.size() == 0);
    repeat (12000) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
